### rtl/core/kadfq_pkg.sv
`default_nettype none

package kadfq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 4;
   localparam int TAG_W               = 32;

   // request function codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_TAKE = 1'b1;

   // stream codes
   localparam logic STREAM_MAIN = 1'b0;
   localparam logic STREAM_SUB  = 1'b1;

   typedef enum logic {
      OP_PUSH,
      OP_TAKE
   } op_type;

   typedef struct packed {
      logic             func;
      logic             stream;
      logic             key_frame;
      logic [TAG_W-1:0] frame_tag;
   } req_type;

   typedef struct packed {
      logic             accepted;
      logic             evicted;
      logic [TAG_W-1:0] evicted_tag;
      logic             out_valid;
      logic             out_stream;
      logic             out_key;
      logic [TAG_W-1:0] out_tag;
   } rsp_type;

   // classified command, front to back
   typedef struct packed {
      op_type           op;
      logic             stream;
      logic             key_frame;
      logic [TAG_W-1:0] frame_tag;
   } cmd_type;

   // one stored queue entry
   typedef struct packed {
      logic             key_frame;
      logic [TAG_W-1:0] frame_tag;
   } entry_type;

endpackage

`default_nettype wire

### rtl/core/kadfq_ram.sv
`default_nettype none

module kadfq_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/kadfq_front.sv
`default_nettype none

module kadfq_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire kadfq_pkg::req_type  req_data,
   output logic                     cmd_valid,
   output kadfq_pkg::cmd_type       cmd_data,
   input  wire logic                cmd_pop
);

   // two-entry command queue
   kadfq_pkg::cmd_type cmd_ff [2];
   kadfq_pkg::cmd_type cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   always_comb begin
      cmd_in.op        = (req_data.func == kadfq_pkg::FUNC_TAKE) ? kadfq_pkg::OP_TAKE
                                                                 : kadfq_pkg::OP_PUSH;
      cmd_in.stream    = req_data.stream;
      cmd_in.key_frame = req_data.key_frame;
      cmd_in.frame_tag = req_data.frame_tag;
   end

   assign full      = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_data  = cmd_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/kadfq_back.sv
`default_nettype none

module kadfq_back #(
   parameter int QUEUE_DEPTH = kadfq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire kadfq_pkg::cmd_type cmd_data,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   output kadfq_pkg::rsp_type      rsp_data,
   input  wire logic               rsp_pop
);

   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = SW + 1;
   localparam int EW = $bits(kadfq_pkg::entry_type);
   localparam logic [SW:0]   DEPTH_EXT = (SW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
   localparam logic [SW-1:0] LAST_POS  = SW'(QUEUE_DEPTH - 1);
   localparam logic [SW-1:0] ONE_POS   = SW'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT_RD,
      ST_SHIFT,
      ST_PUT,
      ST_TAKE_RD
   } state_type;

   function automatic logic [SW-1:0] ring(input logic [SW-1:0] base,
                                          input logic [SW-1:0] off);
      logic [SW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[SW-1:0];
   endfunction

   state_type                      state_ff, state_in;
   logic [SW-1:0]                  idx_ff, idx_in;
   logic                           evict_head_ff, evict_head_in;
   kadfq_pkg::cmd_type             cur_ff, cur_in;
   logic [kadfq_pkg::TAG_W-1:0]    gone_ff, gone_in;
   logic [1:0][SW-1:0]             head_ff, head_in;
   logic [1:0][CW-1:0]             count_ff, count_in;
   logic                           last_ff, last_in;
   logic [1:0][QUEUE_DEPTH-1:0]    key_ff, key_in;
   kadfq_pkg::rsp_type             res_ff, res_in;
   logic                           res_valid_ff, res_valid_in;

   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr, ram_raddr;
   kadfq_pkg::entry_type           ram_wdata, ram_rdata;

   // oldest plain (non-key) entry of the addressed stream, in ring order
   logic [QUEUE_DEPTH-1:0]         plain_vec, plain_rot;
   logic [2*QUEUE_DEPTH-1:0]       plain_dbl;
   logic                           plain_found;
   logic [SW-1:0]                  plain_pos;

   always_comb begin
      plain_vec   = ~key_ff[cmd_data.stream];
      plain_dbl   = {plain_vec, plain_vec} >> head_ff[cmd_data.stream];
      plain_rot   = plain_dbl[QUEUE_DEPTH-1:0];
      plain_found = 1'b0;
      plain_pos   = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (plain_rot[i]) begin
            plain_found = 1'b1;
            plain_pos   = SW'(i);
         end
      end
   end

   kadfq_ram #(
      .WIDTH (EW),
      .DEPTH (2 ** AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      logic          out_free;
      logic          s;
      logic          ts;
      logic [SW-1:0] slot;
      logic [SW:0]   nxt;

      state_in      = state_ff;
      idx_in        = idx_ff;
      evict_head_in = evict_head_ff;
      cur_in        = cur_ff;
      gone_in       = gone_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      key_in        = key_ff;
      res_in        = res_ff;
      out_free      = !res_valid_ff || rsp_pop;
      res_valid_in  = res_valid_ff && !rsp_pop;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;
      s             = cur_ff.stream;
      ts            = kadfq_pkg::STREAM_MAIN;
      slot          = '0;
      nxt           = '0;

      case (state_ff)
         ST_IDLE: begin
            // start only when the result register is free at the finish
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               cur_in  = cmd_data;
               res_in  = '0;
               s       = cmd_data.stream;
               case (cmd_data.op)
                  kadfq_pkg::OP_PUSH: begin
                     if (count_ff[s] < DEPTH_CNT) begin
                        slot                 = ring(head_ff[s], count_ff[s][SW-1:0]);
                        ram_we               = 1'b1;
                        ram_waddr            = {s, slot};
                        ram_wdata.key_frame  = cmd_data.key_frame;
                        ram_wdata.frame_tag  = cmd_data.frame_tag;
                        key_in[s][slot]      = cmd_data.key_frame;
                        count_in[s]          = count_ff[s] + CW'(1);
                        res_in.accepted      = 1'b1;
                        res_valid_in         = 1'b1;
                     end else if (plain_found) begin
                        ram_raddr     = {s, ring(head_ff[s], plain_pos)};
                        idx_in        = plain_pos;
                        evict_head_in = 1'b0;
                        state_in      = ST_EVICT_RD;
                     end else if (cmd_data.key_frame) begin
                        ram_raddr     = {s, head_ff[s]};
                        evict_head_in = 1'b1;
                        state_in      = ST_EVICT_RD;
                     end else begin
                        // all-key queue, plain push: reject
                        res_valid_in = 1'b1;
                     end
                  end
                  kadfq_pkg::OP_TAKE: begin
                     ts = (last_ff == kadfq_pkg::STREAM_SUB) ? kadfq_pkg::STREAM_MAIN
                                                             : kadfq_pkg::STREAM_SUB;
                     if (count_ff[ts] == '0) begin
                        ts = ~ts;
                     end
                     if (count_ff[ts] == '0) begin
                        res_valid_in = 1'b1;
                     end else begin
                        ram_raddr     = {ts, head_ff[ts]};
                        cur_in.stream = ts;
                        state_in      = ST_TAKE_RD;
                     end
                  end
                  default: begin
                     res_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_EVICT_RD: begin
            gone_in = ram_rdata.frame_tag;
            if (evict_head_ff) begin
               // replace the head in place, then advance the head
               ram_we              = 1'b1;
               ram_waddr           = {s, head_ff[s]};
               ram_wdata.key_frame = cur_ff.key_frame;
               ram_wdata.frame_tag = cur_ff.frame_tag;
               key_in[s][head_ff[s]] = cur_ff.key_frame;
               head_in[s]          = ring(head_ff[s], ONE_POS);
               res_in.accepted     = 1'b1;
               res_in.evicted      = 1'b1;
               res_in.evicted_tag  = ram_rdata.frame_tag;
               res_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end else if (idx_ff == LAST_POS) begin
               slot                = ring(head_ff[s], LAST_POS);
               ram_we              = 1'b1;
               ram_waddr           = {s, slot};
               ram_wdata.key_frame = cur_ff.key_frame;
               ram_wdata.frame_tag = cur_ff.frame_tag;
               key_in[s][slot]     = cur_ff.key_frame;
               res_in.accepted     = 1'b1;
               res_in.evicted      = 1'b1;
               res_in.evicted_tag  = ram_rdata.frame_tag;
               res_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               nxt       = {1'b0, idx_ff} + (SW + 1)'(1);
               ram_raddr = {s, ring(head_ff[s], nxt[SW-1:0])};
               state_in  = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // close the gap one entry per cycle
            slot            = ring(head_ff[s], idx_ff);
            ram_we          = 1'b1;
            ram_waddr       = {s, slot};
            ram_wdata       = ram_rdata;
            key_in[s][slot] = ram_rdata.key_frame;
            nxt             = {1'b0, idx_ff} + (SW + 1)'(1);
            idx_in          = nxt[SW-1:0];
            if (nxt[SW-1:0] == LAST_POS) begin
               state_in = ST_PUT;
            end else begin
               nxt       = {1'b0, idx_ff} + (SW + 1)'(2);
               ram_raddr = {s, ring(head_ff[s], nxt[SW-1:0])};
            end
         end

         ST_PUT: begin
            slot                = ring(head_ff[s], LAST_POS);
            ram_we              = 1'b1;
            ram_waddr           = {s, slot};
            ram_wdata.key_frame = cur_ff.key_frame;
            ram_wdata.frame_tag = cur_ff.frame_tag;
            key_in[s][slot]     = cur_ff.key_frame;
            res_in.accepted     = 1'b1;
            res_in.evicted      = 1'b1;
            res_in.evicted_tag  = gone_ff;
            res_valid_in        = 1'b1;
            state_in            = ST_IDLE;
         end

         ST_TAKE_RD: begin
            res_in.out_valid  = 1'b1;
            res_in.out_stream = s;
            res_in.out_key    = ram_rdata.key_frame;
            res_in.out_tag    = ram_rdata.frame_tag;
            res_valid_in      = 1'b1;
            head_in[s]        = ring(head_ff[s], ONE_POS);
            count_in[s]       = count_ff[s] - CW'(1);
            last_in           = s;
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      evict_head_ff <= evict_head_in;
      cur_ff        <= cur_in;
      gone_ff       <= gone_in;
      key_ff        <= key_in;
      res_ff        <= res_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         last_ff      <= kadfq_pkg::STREAM_SUB;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         res_valid_ff <= res_valid_in;
      end
   end

   assign rsp_valid = res_valid_ff;
   assign rsp_data  = res_ff;

endmodule

`default_nettype wire

### rtl/core/keyframe_aware_dual_frame_queue.sv
`default_nettype none

// Channel    Ports                      Transfer when
// ---------  -------------------------  ----------------------
// request    push, full, req_data       push && !full
// response   empty, pop, rsp_data       pop && !empty
//
// A request is registered in the front command queue; the back end then
// answers in ST_IDLE (push into a non-full queue, take with both queues
// empty), via ST_TAKE_RD (take), ST_EVICT_RD (key push evicting the head of
// an all-key queue) or, when the oldest plain entry is dropped, ST_EVICT_RD,
// ST_SHIFT, ST_PUT (ST_EVICT_RD alone if it is last), the one-read one-write
// entry RAM moving one entry per cycle. Reset is synchronous; no clear pass.
// The back end starts an item only when the response register is free.

module keyframe_aware_dual_frame_queue #(
   parameter int QUEUE_DEPTH = kadfq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire kadfq_pkg::req_type req_data,
   output logic                    empty,
   input  wire logic               pop,
   output kadfq_pkg::rsp_type      rsp_data
);

   // front-to-back command hand-off
   logic               cmd_valid;
   logic               cmd_pop;
   kadfq_pkg::cmd_type cmd_data;
   logic               rsp_valid;

   // front: accepts requests and decodes them into push/take commands
   kadfq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // back: queue state, drop scan, compaction and round-robin service
   kadfq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_pop   (pop)
   );

   assign empty = ~rsp_valid;

endmodule

`default_nettype wire

### rtl/core/kadfq_checker.sv
`default_nettype none

module kadfq_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               full,
   input wire logic               empty,
   input wire logic               pop,
   input wire kadfq_pkg::rsp_type rsp_data
);

   // both channels come out of reset idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue not idle after reset");

   // a waiting response holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("response changed before transfer");

   // push and take results never mix; an eviction implies the push stored
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.accepted || rsp_data.evicted)) |->
      (rsp_data.accepted && !rsp_data.out_valid))
      else $error("mixed push/take response");

   // no taken frame: take fields are all zero
   a_take_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.out_valid) |->
      (!rsp_data.out_stream && !rsp_data.out_key && (rsp_data.out_tag == '0)))
      else $error("take fields set without a frame");

endmodule

bind keyframe_aware_dual_frame_queue kadfq_checker u_checker (.*);

`default_nettype wire
